/* hdl/facd_pkg.sv */
// Shared types and constants for the fuzzy alpha-cut dilation block.
`default_nettype none
package facd_pkg;

	localparam int ALU_W      = 50;  // datapath width of the iterative unit
	localparam int STEP_W     = 6;   // iteration counter width
	localparam int MUL_STEPS  = 17;  // multiplier bits, |g - ma| <= 65536
	localparam int DIV_STEPS  = 50;  // one quotient bit per step
	localparam int SQRT_STEPS = 17;  // result bits of the square root
	localparam int MEM_W      = 17;  // Q1.16 membership width
	localparam int BND_W      = 32;  // Q16.16 bound width
	localparam logic [MEM_W-1:0] ONE_Q16 = 17'd65536;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} facd_op_t;

	// Request into the shared iterative unit.
	typedef struct packed {
		logic             start;
		facd_op_t         op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} facd_req_t;

endpackage
`default_nettype wire

/* hdl/facd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module facd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 17
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/facd_iter.sv */
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
`default_nettype none
module facd_iter
	import facd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire facd_req_t        req,
	output logic                  done,
	output logic      [ALU_W-1:0] result
);

	facd_op_t          op_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [ALU_W-1:0]  acc_q, x_q, y_q;
	logic [ALU_W-1:0]  acc_d, x_d, y_d;
	logic [ALU_W-1:0]  r2, t;

	always_comb begin
		acc_d = acc_q;
		x_d   = x_q;
		y_d   = y_q;
		r2    = {acc_q[ALU_W-2:0], x_q[ALU_W-1]};
		t     = x_q + y_q;
		unique case (op_q)
			OP_MUL: begin
				acc_d = y_q[0] ? acc_q + x_q : acc_q;
				x_d   = {x_q[ALU_W-2:0], 1'b0};
				y_d   = {1'b0, y_q[ALU_W-1:1]};
			end
			OP_DIV: begin
				// shift in next dividend bit, subtract if it fits
				if (r2 >= y_q) begin
					acc_d = r2 - y_q;
					x_d   = {x_q[ALU_W-2:0], 1'b1};
				end else begin
					acc_d = r2;
					x_d   = {x_q[ALU_W-2:0], 1'b0};
				end
			end
			OP_SQRT: begin
				if (acc_q >= t) begin
					acc_d = acc_q - t;
					x_d   = {1'b0, x_q[ALU_W-1:1]} + y_q;
				end else begin
					x_d   = {1'b0, x_q[ALU_W-1:1]};
				end
				y_d = {2'b00, y_q[ALU_W-1:2]};
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				unique case (req.op)
					OP_MUL:  cnt_q <= STEP_W'(MUL_STEPS);
					OP_DIV:  cnt_q <= STEP_W'(DIV_STEPS);
					default: cnt_q <= STEP_W'(SQRT_STEPS);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == OP_SQRT) begin
				acc_q <= req.a;
				x_q   <= '0;
				y_q   <= ALU_W'(64'h1_0000_0000);
			end else begin
				acc_q <= '0;
				x_q   <= req.a;
				y_q   <= req.b;
			end
		end else if (busy_q) begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
		end
	end

	assign done   = done_q;
	assign result = (op_q == OP_MUL) ? acc_q : x_q;

endmodule
`default_nettype wire

/* hdl/fuzzy_alpha_cut_dilation_top.sv */
// Top level: level loading, root pass and grid resampling of a fuzzy number.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata levels, s_tlast = final level
//  m_*     | out       | m_tvalid/m_tready  | m_tdata resampled level, m_tuser, m_tlast
//
// Loading takes one level per cycle; s_tready is high only while loading.
// After the final level each stored membership goes through the shared unit
// for its square root, then each of the LEVELS grid points costs a search of
// the stored roots plus, unless the bracketing pair is degenerate, two
// multiplies and two divides, one of each per bound.
// The output register holds a result until taken; reset is asynchronous.
`default_nettype none
module fuzzy_alpha_cut_dilation_top
	import facd_pkg::*;
#(
	parameter int LEVELS = 17
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // membership[16:0], left_bound[48:17], right_bound[80:49]
	input  wire logic        s_tlast,  // last_level
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [87:0] m_tdata,  // grid_membership[16:0], new_left[48:17], new_right[80:49]
	output logic             m_tuser,  // degenerate
	output logic             m_tlast   // last_result
);

	localparam int AW    = $clog2(LEVELS);
	localparam int CW    = $clog2(LEVELS + 1);
	localparam int RW    = AW + 1;
	localparam int DIVR  = LEVELS - 1;
	localparam int GSTEP = 65536 / DIVR;
	localparam int GREM  = 65536 % DIVR;

	typedef enum logic [3:0] {
		S_LOAD, S_RT_RD, S_RT_CAP, S_RT_RUN, S_SR, S_SR_CMP,
		S_FA, S_FB, S_FC, S_PREP, S_MUL, S_DIV, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q, n_q, k_q;
	logic [AW-1:0]     j_q, i_q;
	logic [MEM_W-1:0]  g_q, ma_q, mb_q;
	logic [RW-1:0]     r_q;
	logic [BND_W-1:0]  la_q, lb_q, ra_q, rb_q, res_l_q, res_r_q;
	logic              side_q, deg_q;
	logic              m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [87:0]       m_tdata_q;

	facd_req_t         req;
	logic              it_done;
	logic [ALU_W-1:0]  it_res;

	logic              we, single, out_load, last_pt;
	logic [AW-1:0]     waddr, raddr, ja, jb;
	logic [MEM_W-1:0]  root_wdata, root_rdata, m_sat;
	logic [BND_W-1:0]  left_rdata, right_rdata, va, vb;
	logic signed [32:0] dv;
	logic signed [17:0] dg, dm;
	logic [32:0]       dv_abs;
	logic [17:0]       dg_abs, dm_abs;
	logic              neg;
	logic signed [50:0] sum;
	logic [BND_W-1:0]  sat;
	logic [RW-1:0]     rsum;

	assign m_sat  = (s_tdata[16:0] > ONE_Q16) ? ONE_Q16 : s_tdata[16:0];
	assign single = n_q < CW'(2);
	assign ja     = single ? '0 : j_q - AW'(1);
	assign jb     = single ? '0 : j_q;

	always_comb begin
		we         = 1'b0;
		waddr      = cnt_q[AW-1:0];
		root_wdata = m_sat;
		if (state_q == S_LOAD) begin
			we = s_tvalid && (cnt_q < CW'(LEVELS));
		end else if (state_q == S_RT_RUN) begin
			we         = it_done;
			waddr      = k_q[AW-1:0];
			root_wdata = it_res[MEM_W-1:0];
		end
		unique case (state_q)
			S_RT_RD:  raddr = k_q[AW-1:0];
			S_SR:     raddr = j_q;
			S_FA:     raddr = ja;
			default:  raddr = jb;
		endcase
	end

	facd_ram #(.WIDTH(MEM_W), .DEPTH(LEVELS)) u_root (
		.clk(clk), .we(we), .waddr(waddr), .wdata(root_wdata),
		.raddr(raddr), .rdata(root_rdata)
	);
	facd_ram #(.WIDTH(BND_W), .DEPTH(LEVELS)) u_left (
		.clk(clk), .we(we && state_q == S_LOAD), .waddr(waddr), .wdata(s_tdata[48:17]),
		.raddr(raddr), .rdata(left_rdata)
	);
	facd_ram #(.WIDTH(BND_W), .DEPTH(LEVELS)) u_right (
		.clk(clk), .we(we && state_q == S_LOAD), .waddr(waddr), .wdata(s_tdata[80:49]),
		.raddr(raddr), .rdata(right_rdata)
	);

	facd_iter u_iter (
		.clk(clk), .arst_n(arst_n), .req(req), .done(it_done), .result(it_res)
	);

	// interpolation operands for the current side
	assign va     = side_q ? ra_q : la_q;
	assign vb     = side_q ? rb_q : lb_q;
	assign dv     = {vb[31], vb} - {va[31], va};
	assign dg     = $signed({1'b0, g_q}) - $signed({1'b0, ma_q});
	assign dm     = $signed({1'b0, mb_q}) - $signed({1'b0, ma_q});
	assign dv_abs = dv[32] ? 33'(-dv) : 33'(dv);
	assign dg_abs = dg[17] ? 18'(-dg) : 18'(dg);
	assign dm_abs = dm[17] ? 18'(-dm) : 18'(dm);
	assign neg    = dv[32] ^ dg[17] ^ dm[17];
	assign sum    = 51'(signed'(va)) + (neg ? -$signed({1'b0, it_res}) : $signed({1'b0, it_res}));
	assign sat    = (sum > 51'sd2147483647)  ? 32'h7FFF_FFFF :
	                (sum < -51'sd2147483648) ? 32'h8000_0000 : sum[31:0];
	assign rsum   = r_q + RW'(GREM);
	assign last_pt = (i_q == AW'(LEVELS - 1));
	assign out_load = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);

	always_comb begin
		req = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
		unique case (state_q)
			S_RT_CAP: begin
				req.start = 1'b1;
				req.op    = OP_SQRT;
				req.a     = ALU_W'({root_rdata, 16'b0});
			end
			S_PREP: begin
				req.start = (ma_q != mb_q) && !single;
				req.op    = OP_MUL;
				req.a     = ALU_W'(dv_abs);
				req.b     = ALU_W'(dg_abs);
			end
			S_MUL: begin
				req.start = it_done;
				req.op    = OP_DIV;
				req.a     = it_res;
				req.b     = ALU_W'(dm_abs);
			end
			default: req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			n_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
			i_q        <= '0;
			g_q        <= '0;
			r_q        <= '0;
			side_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (s_tvalid) begin
						if (cnt_q < CW'(LEVELS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (s_tlast) begin
							n_q     <= (cnt_q < CW'(LEVELS)) ? cnt_q + CW'(1) : cnt_q;
							k_q     <= '0;
							state_q <= S_RT_RD;
						end
					end
				end
				S_RT_RD:  state_q <= S_RT_CAP;
				S_RT_CAP: state_q <= S_RT_RUN;
				S_RT_RUN: begin
					if (it_done) begin
						k_q <= k_q + CW'(1);
						if (k_q + CW'(1) == n_q) begin
							i_q     <= '0;
							g_q     <= '0;
							r_q     <= '0;
							j_q     <= AW'(1);
							state_q <= S_SR;
						end else begin
							state_q <= S_RT_RD;
						end
					end
				end
				S_SR: begin
					if (single || (CW'(j_q) >= n_q - CW'(1))) begin
						state_q <= S_FA;
					end else begin
						state_q <= S_SR_CMP;
					end
				end
				S_SR_CMP: begin
					if (root_rdata > g_q) begin
						state_q <= S_FA;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_SR;
					end
				end
				S_FA: state_q <= S_FB;
				S_FB: state_q <= S_FC;
				S_FC: begin
					side_q  <= 1'b0;
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= (single || ma_q == mb_q) ? S_EMIT : S_MUL;
				end
				S_MUL: begin
					if (it_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (it_done) begin
						if (!side_q) begin
							side_q  <= 1'b1;
							state_q <= S_PREP;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						if (last_pt) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q <= i_q + AW'(1);
							j_q <= AW'(1);
							// advance grid value by 65536/(LEVELS-1) with remainder carry
							if (rsum >= RW'(DIVR)) begin
								r_q <= rsum - RW'(DIVR);
								g_q <= g_q + MEM_W'(GSTEP + 1);
							end else begin
								r_q <= rsum;
								g_q <= g_q + MEM_W'(GSTEP);
							end
							state_q <= S_SR;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FB) begin
			ma_q <= root_rdata;
			la_q <= left_rdata;
			ra_q <= right_rdata;
		end
		if (state_q == S_FC) begin
			mb_q <= root_rdata;
			lb_q <= left_rdata;
			rb_q <= right_rdata;
		end
		if (state_q == S_PREP && (single || ma_q == mb_q)) begin
			res_l_q <= la_q;
			res_r_q <= ra_q;
			deg_q   <= 1'b1;
		end
		if (state_q == S_DIV && it_done) begin
			deg_q <= 1'b0;
			if (!side_q) begin
				res_l_q <= sat;
			end else begin
				res_r_q <= sat;
			end
		end
		if (out_load) begin
			m_tdata_q <= {7'b0, res_r_q, res_l_q, g_q};
			m_tuser_q <= deg_q;
			m_tlast_q <= last_pt;
		end
	end

	assign s_tready = (state_q == S_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		it_done |-> (state_q == S_RT_RUN || state_q == S_MUL || state_q == S_DIV))
		else $error("iterative unit finished with no consumer waiting");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LEVELS) && n_q <= CW'(LEVELS))
		else $error("level count beyond store depth");

	a_pair_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FA) |-> (CW'(jb) < n_q))
		else $error("bracketing pair reads an unloaded level");

	a_final_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_pt) |=> (state_q == S_LOAD && cnt_q == '0))
		else $error("block did not return to loading after final result");

endmodule
`default_nettype wire

/* bench/fuzzy_alpha_cut_dilation_top_test.sv */
// Self-checking bench for the fuzzy alpha-cut dilation top level.
`default_nettype none
module fuzzy_alpha_cut_dilation_top_test;
	import facd_pkg::*;

	localparam int LEVELS = 17;
	localparam int N_ITEMS = 160;

	typedef struct {
		logic [MEM_W-1:0] grid;
		logic [BND_W-1:0] left;
		logic [BND_W-1:0] right;
		logic             degen;
		logic             last;
	} dilated_level_t;

	typedef struct {
		logic [MEM_W-1:0] memb;
		logic [BND_W-1:0] left;
		logic [BND_W-1:0] right;
		logic             last;
		logic             typed;  // results read off by hand: bounds below, degenerate
		logic [BND_W-1:0] exp_left;
		logic [BND_W-1:0] exp_right;
	} level_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	fuzzy_alpha_cut_dilation_top #(.LEVELS(LEVELS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	dilated_level_t expected_levels[$];
	int unsigned    mismatches = 0;
	bit             quiet = 0;  // no idling in the final stretch

	// predictor state
	logic [MEM_W-1:0] held_memb[LEVELS];
	longint           held_left[LEVELS];
	longint           held_right[LEVELS];
	int unsigned      held_count = 0;

	function automatic longint unsigned root_q16(longint unsigned x);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic longint lerp_sat(longint g, longint ma, longint mb, longint va,
			longint vb);
		longint v;
		v = va + ((g - ma) * (vb - va)) / (mb - ma);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v;
	endfunction

	// Load one level; on the final level, return the resampled operand.
	function automatic void dilate_level(logic [MEM_W-1:0] memb, logic [BND_W-1:0] left,
			logic [BND_W-1:0] right, logic last, ref dilated_level_t res[$]);
		longint unsigned roots[LEVELS];
		longint g;
		int unsigned n;
		int unsigned j;
		dilated_level_t d;
		res.delete();
		if (memb > ONE_Q16)
			memb = ONE_Q16;
		if (held_count < LEVELS) begin
			held_memb[held_count]  = memb;
			held_left[held_count]  = longint'($signed(left));
			held_right[held_count] = longint'($signed(right));
			held_count++;
		end
		if (!last)
			return;
		n = held_count;
		for (int k = 0; k < n; k++)
			roots[k] = root_q16(longint'(held_memb[k]) << 16);
		for (int i = 0; i < LEVELS; i++) begin
			g = (longint'(i) * 65536) / (LEVELS - 1);
			d.grid = g[MEM_W-1:0];
			d.last = (i == LEVELS - 1);
			if (n < 2) begin
				d.left  = held_left[0][31:0];
				d.right = held_right[0][31:0];
				d.degen = 1'b1;
			end else begin
				for (j = 1; j < n - 1; j++)
					if (longint'(roots[j]) > g)
						break;
				if (roots[j] == roots[j-1]) begin
					d.left  = held_left[j-1][31:0];
					d.right = held_right[j-1][31:0];
					d.degen = 1'b1;
				end else begin
					d.left  = BND_W'(lerp_sat(g, roots[j-1], roots[j], held_left[j-1],
						held_left[j]));
					d.right = BND_W'(lerp_sat(g, roots[j-1], roots[j], held_right[j-1],
						held_right[j]));
					d.degen = 1'b0;
				end
			end
			res.push_back(d);
		end
		held_count = 0;
	endfunction

	task automatic idle_burst();
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(15, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_level(level_row_t row);
		dilated_level_t res[$];
		dilated_level_t d;
		idle_burst();
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, row.right, row.left, row.memb};
		s_tlast  <= row.last;
		do @(posedge clk); while (!s_tready);
		dilate_level(row.memb, row.left, row.right, row.last, res);
		if (row.typed && row.last) begin
			// overwrite bounds with the hand-typed values
			foreach (res[k]) begin
				d = res[k];
				d.left  = row.exp_left;
				d.right = row.exp_right;
				d.degen = 1'b1;
				res[k] = d;
			end
		end
		foreach (res[k])
			expected_levels.push_back(res[k]);
	endtask

	// result side: random stalls, compare against oldest expectation
	int stall_left = 0;
	always @(posedge clk) begin
		dilated_level_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				e = expected_levels.pop_front();
				if (m_tdata[16:0] !== e.grid || m_tdata[48:17] !== e.left ||
						m_tdata[80:49] !== e.right || m_tdata[87:81] !== 7'd0 ||
						m_tuser !== e.degen || m_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp grid=%h l=%h r=%h deg=%b last=%b, ",
							e.grid, e.left, e.right, e.degen, e.last);
						$display("got grid=%h l=%h r=%h deg=%b last=%b",
							m_tdata[16:0], m_tdata[48:17], m_tdata[80:49],
							m_tuser, m_tlast);
					end
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(3) == 0) begin
			stall_left <= $urandom_range(14, 0);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic level_row_t mk(logic [MEM_W-1:0] m, logic [BND_W-1:0] l,
			logic [BND_W-1:0] r, logic last);
		level_row_t row;
		row.memb = m;
		row.left = l;
		row.right = r;
		row.last = last;
		row.typed = 1'b0;
		row.exp_left = '0;
		row.exp_right = '0;
		return row;
	endfunction

	function automatic level_row_t mk_typed(logic [MEM_W-1:0] m, logic [BND_W-1:0] l,
			logic [BND_W-1:0] r, logic [BND_W-1:0] el, logic [BND_W-1:0] er);
		level_row_t row;
		row = mk(m, l, r, 1'b1);
		row.typed = 1'b1;
		row.exp_left = el;
		row.exp_right = er;
		return row;
	endfunction

	initial begin
		level_row_t directed[$];
		int unsigned memb_q[$];
		int unsigned sent;
		int unsigned n;
		bit noisy;
		logic [BND_W-1:0] l;
		logic [BND_W-1:0] r;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single level: every grid point repeats its bounds
		directed.push_back(mk_typed(17'd0, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff));
		directed.push_back(mk_typed(17'd65536, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000));
		// membership above one saturates
		directed.push_back(mk_typed(17'h1ffff, 32'h0001_0000, 32'h0002_0000,
			32'h0001_0000, 32'h0002_0000));
		// equal memberships give the lower level's bounds
		directed.push_back(mk(17'd65536, 32'h0003_0000, 32'h0005_0000, 1'b0));
		directed.push_back(mk_typed(17'd65536, 32'h0009_0000, 32'h000a_0000,
			32'h0003_0000, 32'h0005_0000));
		// plain triangle
		directed.push_back(mk(17'd0, 32'hff9c_0000, 32'h0064_0000, 1'b0));
		directed.push_back(mk(17'd16384, 32'hffce_0000, 32'h0032_0000, 1'b0));
		directed.push_back(mk(17'd65536, 32'h0000_0000, 32'h0000_0000, 1'b1));
		// steep slope forces saturation on extrapolation
		directed.push_back(mk(17'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
		directed.push_back(mk(17'd1, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
		// grid below first level, descending noise, extremes of bits
		directed.push_back(mk(17'd40000, 32'h5555_5555, 32'haaaa_aaaa, 1'b0));
		directed.push_back(mk(17'd50000, 32'haaaa_aaaa, 32'h5555_5555, 1'b0));
		directed.push_back(mk(17'd20000, 32'hffff_ffff, 32'h0000_0000, 1'b0));
		directed.push_back(mk(17'd65535, 32'h0000_0000, 32'hffff_ffff, 1'b1));

		foreach (directed[k])
			send_level(directed[k]);
		sent = directed.size();

		// hold the sender until the directed results have drained
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);

		while (sent < N_ITEMS) begin
			if (sent > N_ITEMS - 30)
				quiet = 1;
			case ($urandom_range(9))
				0:       n = 1;
				1:       n = $urandom_range(20, 17);  // store full
				default: n = $urandom_range(8, 2);
			endcase
			noisy = ($urandom_range(7) == 0);
			memb_q.delete();
			for (int k = 0; k < n; k++) begin
				if (noisy)
					memb_q.push_back($urandom_range(131071));
				else if ($urandom_range(5) == 0 && k > 0)
					memb_q.push_back(memb_q[k-1]);  // duplicate level
				else
					memb_q.push_back($urandom_range(65536));
			end
			if (!noisy)
				memb_q.sort();
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(4) == 0) begin
					l = $urandom;
					r = $urandom;
				end else begin
					l = $signed($urandom_range(33554431)) - 32'sd16777216;
					r = l + $urandom_range(16777215);
				end
				send_level(mk(MEM_W'(memb_q[k]), l, r, k == n - 1));
			end
			sent += n;
		end
		s_tvalid <= 1'b0;

		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (3000) @(posedge clk);
		if (mismatches == 0)
			$display("fuzzy_alpha_cut_dilation_top_test: done, clean");
		else
			$display("fuzzy_alpha_cut_dilation_top_test: done, errors");
		$finish;
	end

	initial begin
		#(20 * 4_000_000);
		$display("fuzzy_alpha_cut_dilation_top_test: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
